/* hdl/ttw_pkg.sv */
// ----------------------------------------------------------------------------
// ttw_pkg
// shared constants, codes and types of the text terminal writer
// ----------------------------------------------------------------------------
package ttw_pkg;

  // default grid geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 24;

  // field widths
  localparam int KIND_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int CELL_W       = ATTR_W + CHAR_W;
  localparam int CELL_INDEX_W = 11;
  localparam int ROW_OUT_W    = 5;
  localparam int COL_OUT_W    = 7;
  localparam int CFG_INDEX_W  = 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_ATTRIBUTE = 8'd1;

  // characters and colors
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'd7;

  localparam logic [CELL_W-1:0] RESET_BLANK_CELL = {DEFAULT_ATTR, SPACE_CHAR};

  // command to the sweep engine
  typedef struct packed {
    logic              start;
    logic              copy;       // move rows up one before the blank fill
    logic [CELL_W-1:0] fill_cell;
  } sweep_cmd_t;

endpackage

/* hdl/ttw_screen_ram.sv */
// ----------------------------------------------------------------------------
// ttw_screen_ram
// character cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ttw_screen_ram #(
  parameter int DEPTH = ttw_pkg::DEF_ROWS * ttw_pkg::DEF_COLUMNS
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [ttw_pkg::CELL_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [ttw_pkg::CELL_W-1:0] rdata
);
  import ttw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ttw_sweep.sv */
// ----------------------------------------------------------------------------
// ttw_sweep
// address sequencer for scroll copy and blank fill, one cell per cycle
// ----------------------------------------------------------------------------
module ttw_sweep #(
  parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
  parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ttw_pkg::sweep_cmd_t                  cmd,
  output logic                                 busy,
  output logic                                 we,
  output logic [$clog2(ROWS*COLUMNS)-1:0]      waddr,
  output logic [ttw_pkg::CELL_W-1:0]           wdata,
  output logic                                 re,
  output logic [$clog2(ROWS*COLUMNS)-1:0]      raddr,
  input  logic [ttw_pkg::CELL_W-1:0]           rdata
);
  import ttw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  typedef enum logic [1:0] {SW_IDLE, SW_COPY, SW_FILL} sw_state_t;

  sw_state_t         state;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wr_addr;
  logic              pend;
  logic [CELL_W-1:0] fill_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_IDLE;
      pend  <= 1'b0;
    end else begin
      case (state)
        SW_IDLE: begin
          if (cmd.start) begin
            fill_cell <= cmd.fill_cell;
            cnt       <= '0;
            pend      <= 1'b0;
            state     <= cmd.copy ? SW_COPY : SW_FILL;
          end
        end
        SW_COPY: begin
          // each read's data is written in the cycle after the read
          wr_addr <= cnt;
          pend    <= 1'b1;
          cnt     <= cnt + 1'b1;
          if (cnt == COPY_LAST) begin
            state <= SW_FILL;
          end
        end
        SW_FILL: begin
          if (pend) begin
            pend <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
            if (cnt == CELL_LAST) begin
              state <= SW_IDLE;
            end
          end
        end
        default: state <= SW_IDLE;
      endcase
    end
  end

  always_comb begin
    busy  = (state != SW_IDLE);
    re    = (state == SW_COPY);
    raddr = cnt + ROW_STEP;
    we    = ((state == SW_COPY) && pend) || (state == SW_FILL);
    waddr = pend ? wr_addr : cnt;
    wdata = pend ? rdata : fill_cell;
  end

  // copy never writes the cell being read in the same cycle
  a_copy_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == SW_COPY && pend) |-> (wr_addr != raddr))
    else $error("sweep copy writes the cell it reads");

  // the sweep only ends right after the last cell was written
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> ($past(we) && $past(waddr) == CELL_LAST))
    else $error("sweep ended before the last cell");

  // no new command while a sweep runs
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.start)
    else $error("sweep started while busy");

endmodule

/* hdl/text_terminal_writer.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer
// text-mode character grid with a write cursor, scroll and clear
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       in         in_valid / in_ready    kind, char_code, cell_index
//  out      out        out_valid / out_ready  cell_data, cursor_row,
//                                             cursor_column, scrolled
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  put and unused kinds go straight to the result, a read waits for the registered ram read
//  a scroll copies the rows up and blanks the last row, a clear blanks every cell,
//  both swept one cell per cycle through the single cell write port
//  after reset a blanking pass holds in_ready low;
//  cfg transfers are taken at all times
//  a finished result sits in the output register while the next item is taken
//
module text_terminal_writer #(
  parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
  parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  // item input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ttw_pkg::KIND_W-1:0]       kind,
  input  logic [ttw_pkg::CHAR_W-1:0]       char_code,
  input  logic [ttw_pkg::CELL_INDEX_W-1:0] cell_index,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ttw_pkg::CELL_W-1:0]       cell_data,
  output logic [ttw_pkg::ROW_OUT_W-1:0]    cursor_row,
  output logic [ttw_pkg::COL_OUT_W-1:0]    cursor_column,
  output logic                             scrolled,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ttw_pkg::ATTR_W-1:0]       cfg_data
);
  import ttw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  typedef enum logic [2:0] {
    ST_INIT,      // kick off the reset blanking pass
    ST_BLANKING,  // reset blanking pass in progress
    ST_IDLE,
    ST_READ,      // registered ram read in flight
    ST_SWEEP,     // scroll or clear in progress
    ST_DONE       // result waiting for the output register
  } state_t;

  state_t            state;

  // configuration
  logic [ATTR_W-1:0] text_attribute;
  logic [ATTR_W-1:0] blank_attribute;

  // cursor, with its linear cell address kept alongside
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] pos;

  // pending result
  logic [CELL_W-1:0] res_data;
  logic              res_scrolled;
  logic              rd_ok;

  // item decode
  logic              accept;
  logic              is_newline;
  logic              line_end;
  logic              at_last_row;
  logic              in_range;
  logic [ADDR_W-1:0] next_line_pos;

  // ram and sweep wiring
  sweep_cmd_t        sw_cmd;
  logic              sw_busy;
  logic              sw_we;
  logic [ADDR_W-1:0] sw_waddr;
  logic [CELL_W-1:0] sw_wdata;
  logic              sw_re;
  logic [ADDR_W-1:0] sw_raddr;
  logic              item_we;
  logic              item_re;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    is_newline    = (char_code == NEWLINE_CHAR);
    // newline, or a put in the last column, moves to the next line
    line_end      = is_newline || (col == COL_LAST);
    at_last_row   = (row == ROW_LAST);
    in_range      = (32'(cell_index) < 32'(CELL_COUNT));
    next_line_pos = pos - ADDR_W'(col) + ROW_STEP;
  end

  // sweep requests: reset blanking, scroll on a line end in the last row, clear
  always_comb begin
    sw_cmd.start     = 1'b0;
    sw_cmd.copy      = 1'b0;
    sw_cmd.fill_cell = {blank_attribute, SPACE_CHAR};
    if (state == ST_INIT) begin
      sw_cmd.start     = 1'b1;
      sw_cmd.fill_cell = RESET_BLANK_CELL;
    end else if (accept) begin
      case (kind)
        KIND_PUT: begin
          sw_cmd.start = line_end && at_last_row;
          sw_cmd.copy  = 1'b1;
        end
        KIND_CLEAR: sw_cmd.start = 1'b1;
        default: sw_cmd.start = 1'b0;
      endcase
    end
  end

  // item side ram access happens only at the accept edge
  always_comb begin
    item_we   = accept && (kind == KIND_PUT) && !is_newline;
    item_re   = accept && (kind == KIND_READ);
    ram_we    = sw_busy ? sw_we    : item_we;
    ram_waddr = sw_busy ? sw_waddr : pos;
    ram_wdata = sw_busy ? sw_wdata : {text_attribute, char_code};
    ram_re    = sw_busy ? sw_re    : item_re;
    ram_raddr = sw_busy ? sw_raddr : ADDR_W'(cell_index);
  end

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute  <= DEFAULT_ATTR;
      blank_attribute <= DEFAULT_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEXT_ATTRIBUTE:  text_attribute  <= cfg_data;
        REG_BLANK_ATTRIBUTE: blank_attribute <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      row       <= '0;
      col       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register drains on a transfer unless it is refilled below
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_INIT: state <= ST_BLANKING;

        ST_BLANKING: begin
          if (!sw_busy) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            res_data     <= '0;
            res_scrolled <= 1'b0;
            rd_ok        <= in_range;
            state        <= ST_DONE;
            case (kind)
              KIND_PUT: begin
                if (line_end) begin
                  col <= '0;
                  if (at_last_row) begin
                    // cursor stays on the last row, rows shift up
                    pos          <= LAST_BASE;
                    res_scrolled <= 1'b1;
                    state        <= ST_SWEEP;
                  end else begin
                    row <= row + 1'b1;
                    pos <= next_line_pos;
                  end
                end else begin
                  col <= col + 1'b1;
                  pos <= pos + 1'b1;
                end
              end
              KIND_READ: state <= ST_READ;
              KIND_CLEAR: begin
                row   <= '0;
                col   <= '0;
                pos   <= '0;
                state <= ST_SWEEP;
              end
              default: state <= ST_DONE;
            endcase
          end
        end

        ST_READ: begin
          // out of range reads give zero
          res_data <= rd_ok ? ram_rdata : '0;
          state    <= ST_DONE;
        end

        ST_SWEEP: begin
          if (!sw_busy) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            cell_data     <= res_data;
            cursor_row    <= ROW_OUT_W'(row);
            cursor_column <= COL_OUT_W'(col);
            scrolled      <= res_scrolled;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_INIT;
      endcase
    end
  end

  ttw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_sweep (
    .clk   (clk),
    .rst   (rst),
    .cmd   (sw_cmd),
    .busy  (sw_busy),
    .we    (sw_we),
    .waddr (sw_waddr),
    .wdata (sw_wdata),
    .re    (sw_re),
    .raddr (sw_raddr),
    .rdata (ram_rdata)
  );

  ttw_screen_ram #(
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // no item is taken while the sweep owns the ram
  a_idle_not_sweeping: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sw_busy)
    else $error("item accepted during a sweep");

  // a scrolled result always reports the cursor on the last row
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_row == ROW_OUT_W'(ROWS - 1)))
    else $error("scroll result off the last row");

  // item writes to the ram only come from the idle state
  a_item_write_idle: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !sw_busy) |-> (state == ST_IDLE))
    else $error("item ram write outside idle");

endmodule
